// ----- src/cot_pkg.sv -----
// ----------------------------------------------------------------------------
// cot_pkg: chained one-shot timer table shared types
// Operation and result codes, the walk state type and the control and
// status groups passed between the timer cells, the head unit and the top.
// ----------------------------------------------------------------------------
package cot_pkg;

	localparam int KIND_W  = 2;
	localparam int INUSE_W = 4;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADDED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FULL  = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic fire;
		logic armed;
		logic follows;
	} head_stat_t;

endpackage

// ----- src/chained_oneshot_timer_table.sv -----
// ----------------------------------------------------------------------------
// chained_oneshot_timer_table: ordered table of chained one-shot timers
// Timers sit in a row of cells in insertion order. A tick rotates the row
// through the head unit, which decrements, fires and compacts the row.
//
//   channel  dir  tdata                                   tuser  tlast
//   s_*      in   start_armed, wait_for_previous,         op     -
//                 delay_ticks, action_id
//   m_*      out  fired_action, timers_in_use             kind   last
//
// Add: its result follows through two output registers.
// Tick: the row shifts through the head unit once per timer in use when the
// tick is taken, then the walk closes.
// A fired result waits in a holding register until the next one or the
// walk end fixes its last flag; a stalled output holds the walk only when
// a second result is due. Reset empties the table at once.
// ----------------------------------------------------------------------------
module chained_oneshot_timer_table #(
	parameter int SLOTS       = 8,
	parameter int COUNT_BITS  = 16,
	parameter int ACTION_BITS = 4,
	localparam int S_TDATA_W  = ((2 + COUNT_BITS + ACTION_BITS + 7) / 8) * 8,
	localparam int M_TDATA_W  = ((ACTION_BITS + cot_pkg::INUSE_W + 7) / 8) * 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [S_TDATA_W-1:0]        s_tdata,  // start_armed, wait_for_previous, delay_ticks, action_id
	input  logic                        s_tuser,  // op
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [M_TDATA_W-1:0]        m_tdata,  // fired_action, timers_in_use
	output logic [cot_pkg::KIND_W-1:0]  m_tuser,  // kind
	output logic                        m_tlast
);
	import cot_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	state_t state_q, state_d;

	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       step_q;
	logic [CNT_W-1:0]       walk_n_q;
	logic                   prev_fired_q;

	logic                   pend_valid_q;
	logic                   pend_final_q;
	logic [KIND_W-1:0]      pend_kind_q;
	logic [ACTION_BITS-1:0] pend_act_q;
	logic [INUSE_W-1:0]     pend_cnt_q;

	logic                   out_valid_q;
	logic [KIND_W-1:0]      out_kind_q;
	logic [ACTION_BITS-1:0] out_act_q;
	logic [INUSE_W-1:0]     out_cnt_q;
	logic                   out_last_q;

	logic                   in_op;
	logic                   in_start_armed;
	logic                   in_wait_prev;
	logic [COUNT_BITS-1:0]  in_delay;
	logic [ACTION_BITS-1:0] in_action;

	logic                   accept;
	logic                   add_ok;
	logic                   full;
	logic                   walk_active;
	logic                   fire_req;
	logic                   walk_step;
	logic                   out_can_load;
	logic                   pend_move;
	logic [CNT_W-1:0]       cnt_m1;

	logic                   ld_en;
	logic [IDX_W-1:0]       ld_pos;
	logic                   ld_armed;
	logic                   ld_follows;
	logic [COUNT_BITS-1:0]  ld_rem;
	logic [ACTION_BITS-1:0] ld_act;

	head_stat_t             head_stat;
	logic [COUNT_BITS-1:0]  head_rem_next;

	logic                   c_armed   [SLOTS+1];
	logic                   c_follows [SLOTS+1];
	logic [COUNT_BITS-1:0]  c_rem     [SLOTS+1];
	logic [ACTION_BITS-1:0] c_act     [SLOTS+1];

	assign in_op          = s_tuser;
	assign in_start_armed = s_tdata[0];
	assign in_wait_prev   = s_tdata[1];
	assign in_delay       = s_tdata[2 +: COUNT_BITS];
	assign in_action      = s_tdata[2 + COUNT_BITS +: ACTION_BITS];

	assign c_armed[SLOTS]   = 1'b0;
	assign c_follows[SLOTS] = 1'b0;
	assign c_rem[SLOTS]     = '0;
	assign c_act[SLOTS]     = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		cell_ctl_t ctl;

		always_comb begin
			ctl.shift = walk_step;
			ctl.load  = ld_en && (ld_pos == IDX_W'(i));
		end

		cot_cell #(
			.COUNT_BITS  (COUNT_BITS),
			.ACTION_BITS (ACTION_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.nxt_armed   (c_armed[i+1]),
			.nxt_follows (c_follows[i+1]),
			.nxt_rem     (c_rem[i+1]),
			.nxt_act     (c_act[i+1]),
			.ld_armed    (ld_armed),
			.ld_follows  (ld_follows),
			.ld_rem      (ld_rem),
			.ld_act      (ld_act),
			.armed       (c_armed[i]),
			.follows     (c_follows[i]),
			.rem         (c_rem[i]),
			.act         (c_act[i])
		);
	end

	cot_head #(
		.COUNT_BITS (COUNT_BITS)
	) u_head (
		.prev_fired (prev_fired_q),
		.armed      (c_armed[0]),
		.follows    (c_follows[0]),
		.rem        (c_rem[0]),
		.stat       (head_stat),
		.rem_next   (head_rem_next)
	);

	always_comb begin
		s_tready     = (state_q == ST_IDLE) && !pend_valid_q;
		accept       = s_tvalid && s_tready;
		full         = (cnt_q == CNT_W'(SLOTS));
		add_ok       = accept && (in_op == OP_ADD) && !full;
		walk_active  = (state_q == ST_WALK) && (step_q != walk_n_q);
		fire_req     = walk_active && head_stat.fire;
		out_can_load = !out_valid_q || m_tready;
		walk_step    = walk_active && (!fire_req || !pend_valid_q || out_can_load);
		pend_move    = pend_valid_q && out_can_load && (pend_final_q || (walk_step && fire_req));
		cnt_m1       = cnt_q - CNT_W'(1);
	end

	always_comb begin
		if (state_q == ST_WALK) begin
			ld_en      = walk_step && !head_stat.fire;
			ld_pos     = cnt_m1[IDX_W-1:0];
			ld_armed   = head_stat.armed;
			ld_follows = head_stat.follows;
			ld_rem     = head_rem_next;
			ld_act     = c_act[0];
		end else begin
			ld_en      = add_ok;
			ld_pos     = cnt_q[IDX_W-1:0];
			ld_armed   = in_start_armed;
			ld_follows = in_wait_prev && (cnt_q != '0);
			ld_rem     = in_delay;
			ld_act     = in_action;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_op == OP_TICK)) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (!walk_active) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			step_q       <= '0;
			walk_n_q     <= '0;
			prev_fired_q <= 1'b0;
		end else begin
			if (add_ok) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (walk_step && head_stat.fire) begin
				cnt_q <= cnt_m1;
			end
			if (accept && (in_op == OP_TICK)) begin
				step_q       <= '0;
				walk_n_q     <= cnt_q;
				prev_fired_q <= 1'b0;
			end else if (walk_step) begin
				step_q       <= step_q + CNT_W'(1);
				prev_fired_q <= head_stat.fire;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_final_q <= 1'b0;
		end else begin
			priority if (accept && (in_op == OP_ADD)) begin
				pend_valid_q <= 1'b1;
				pend_final_q <= 1'b1;
			end else if (walk_step && fire_req) begin
				pend_valid_q <= 1'b1;
				pend_final_q <= 1'b0;
			end else if ((state_q == ST_WALK) && !walk_active) begin
				pend_final_q <= 1'b1;
			end else if (pend_move) begin
				pend_valid_q <= 1'b0;
			end else begin
				pend_valid_q <= pend_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (accept && (in_op == OP_ADD)) begin
			pend_kind_q <= full ? KIND_FULL : KIND_ADDED;
			pend_act_q  <= '0;
			pend_cnt_q  <= full ? INUSE_W'(cnt_q) : INUSE_W'({1'b0, cnt_q} + 1'b1);
		end else if (walk_step && fire_req) begin
			pend_kind_q <= KIND_FIRED;
			pend_act_q  <= c_act[0];
			pend_cnt_q  <= INUSE_W'(cnt_m1);
		end else begin
			pend_kind_q <= pend_kind_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_move) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			out_kind_q <= pend_kind_q;
			out_act_q  <= pend_act_q;
			out_cnt_q  <= pend_cnt_q;
			out_last_q <= pend_final_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_cnt_q, out_act_q});
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SLOTS))
		else $error("timer count beyond table size");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (step_q <= walk_n_q))
		else $error("walk step passed its timer count");

	a_fire_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_step && fire_req) |=> (cnt_q == $past(cnt_m1)))
		else $error("fired timer did not free its cell");

	a_idle_final: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && pend_valid_q) |-> pend_final_q)
		else $error("open fired item left after walk");

endmodule

// ----- src/cot_cell.sv -----
// ----------------------------------------------------------------------------
// cot_cell: one timer cell of the ordered row
// Holds one timer: armed flag, follows-predecessor flag, remaining count and
// action. Loads new contents or takes its right neighbor's on a shift.
// ----------------------------------------------------------------------------
module cot_cell #(
	parameter int COUNT_BITS  = 16,
	parameter int ACTION_BITS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cot_pkg::cell_ctl_t     ctl,
	input  logic                   nxt_armed,
	input  logic                   nxt_follows,
	input  logic [COUNT_BITS-1:0]  nxt_rem,
	input  logic [ACTION_BITS-1:0] nxt_act,
	input  logic                   ld_armed,
	input  logic                   ld_follows,
	input  logic [COUNT_BITS-1:0]  ld_rem,
	input  logic [ACTION_BITS-1:0] ld_act,
	output logic                   armed,
	output logic                   follows,
	output logic [COUNT_BITS-1:0]  rem,
	output logic [ACTION_BITS-1:0] act
);
	import cot_pkg::*;

	logic                   armed_q;
	logic                   follows_q;
	logic [COUNT_BITS-1:0]  rem_q;
	logic [ACTION_BITS-1:0] act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			follows_q <= 1'b0;
		end else if (ctl.load) begin
			armed_q   <= ld_armed;
			follows_q <= ld_follows;
		end else if (ctl.shift) begin
			armed_q   <= nxt_armed;
			follows_q <= nxt_follows;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= ld_rem;
			act_q <= ld_act;
		end else if (ctl.shift) begin
			rem_q <= nxt_rem;
			act_q <= nxt_act;
		end
	end

	assign armed   = armed_q;
	assign follows = follows_q;
	assign rem     = rem_q;
	assign act     = act_q;

endmodule

// ----- src/cot_head.sv -----
// ----------------------------------------------------------------------------
// cot_head: head-of-row timer evaluation
// Arms the head timer when its predecessor just fired and it follows it,
// decrements an armed timer and flags expiry at a count of one or zero.
// ----------------------------------------------------------------------------
module cot_head #(
	parameter int COUNT_BITS = 16
) (
	input  logic                  prev_fired,
	input  logic                  armed,
	input  logic                  follows,
	input  logic [COUNT_BITS-1:0] rem,
	output cot_pkg::head_stat_t   stat,
	output logic [COUNT_BITS-1:0] rem_next
);
	import cot_pkg::*;

	logic run;

	always_comb begin
		run          = armed || (prev_fired && follows);
		stat.armed   = run;
		stat.follows = follows && !prev_fired;
		stat.fire    = run && (rem <= COUNT_BITS'(1));
		rem_next     = run ? rem - COUNT_BITS'(1) : rem;
	end

endmodule

// ----- tb/chained_oneshot_timer_table_checker.sv -----
// ----------------------------------------------------------------------------
// chained_oneshot_timer_table_checker: timer table prediction and compare
// Watches both stream channels of the timer table. Every accepted input item
// is run through a local copy of the slot table to work out the results it
// causes. Every accepted result is compared field by field with the oldest
// result still due. Mismatches and the number of results due are reported to
// the testbench top.
// ----------------------------------------------------------------------------
module chained_oneshot_timer_table_checker #(
	parameter int SLOTS       = 8,
	parameter int COUNT_BITS  = 16,
	parameter int ACTION_BITS = 4,
	parameter int S_TDATA_W   = 24,
	parameter int M_TDATA_W   = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [S_TDATA_W-1:0]          s_tdata,  // start_armed, wait_for_previous, delay_ticks, action_id
	input  logic                          s_tuser,  // op
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [M_TDATA_W-1:0]          m_tdata,  // fired_action, timers_in_use
	input  logic [cot_pkg::KIND_W-1:0]    m_tuser,  // kind
	input  logic                          m_tlast,
	output int                            mismatches,
	output int                            results_due
);
	import cot_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0]      kind;
		logic [ACTION_BITS-1:0] action;
		logic [INUSE_W-1:0]     in_use;
		logic                   last;
	} timer_result_t;

	logic                   slot_busy    [SLOTS];
	logic                   slot_running [SLOTS];
	logic [COUNT_BITS-1:0]  slot_count   [SLOTS];
	logic [ACTION_BITS-1:0] slot_act     [SLOTS];
	logic                   slot_linked  [SLOTS];
	int                     slot_next    [SLOTS];
	int                     slot_rank    [SLOTS];
	int                     tail_slot = -1;

	timer_result_t due_results [$];

	function automatic int occupancy();
		int n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (slot_busy[i])
				n++;
		return n;
	endfunction

	task automatic free_timer(input int s);
		int n;
		slot_busy[s]    = 1'b0;
		slot_running[s] = 1'b0;
		slot_linked[s]  = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_busy[i]) begin
				if (slot_rank[i] > slot_rank[s])
					slot_rank[i]--;
				if (slot_linked[i] && slot_next[i] == s)
					slot_linked[i] = 1'b0;
			end
		end
		if (tail_slot == s) begin
			tail_slot = -1;
			n = occupancy();
			for (int i = 0; i < SLOTS; i++)
				if (n > 0 && slot_busy[i] && slot_rank[i] == n - 1)
					tail_slot = i;
		end
	endtask

	task automatic enter_timer(input logic armed_now, input logic link,
			input logic [COUNT_BITS-1:0] delay, input logic [ACTION_BITS-1:0] act);
		int n;
		int s;
		timer_result_t res;
		n = occupancy();
		s = -1;
		for (int i = SLOTS - 1; i >= 0; i--)
			if (!slot_busy[i])
				s = i;
		if (s < 0) begin
			res = '{kind: KIND_FULL, action: '0, in_use: INUSE_W'(n), last: 1'b1};
		end else begin
			slot_busy[s]    = 1'b1;
			slot_running[s] = armed_now;
			slot_count[s]   = delay;
			slot_act[s]     = act;
			slot_linked[s]  = 1'b0;
			slot_next[s]    = 0;
			slot_rank[s]    = n;
			if (link && tail_slot >= 0) begin
				slot_linked[tail_slot] = 1'b1;
				slot_next[tail_slot]   = s;
			end
			tail_slot = s;
			res = '{kind: KIND_ADDED, action: '0, in_use: INUSE_W'(n + 1), last: 1'b1};
		end
		due_results.push_back(res);
	endtask

	task automatic tick_timers();
		int order [SLOTS];
		int n;
		int s;
		logic have_fire;
		timer_result_t fire;
		n = occupancy();
		have_fire = 1'b0;
		for (int r = 0; r < n; r++) begin
			order[r] = -1;
			for (int i = 0; i < SLOTS; i++)
				if (slot_busy[i] && slot_rank[i] == r)
					order[r] = i;
		end
		for (int r = 0; r < n; r++) begin
			s = order[r];
			if (s >= 0 && slot_busy[s] && slot_running[s]) begin
				if (slot_count[s] > 1) begin
					slot_count[s] = slot_count[s] - 1'b1;
				end else begin
					slot_count[s] = '0;
					if (have_fire)
						due_results.push_back(fire);
					fire.kind   = KIND_FIRED;
					fire.action = slot_act[s];
					fire.last   = 1'b0;
					if (slot_linked[s] && slot_busy[slot_next[s]])
						slot_running[slot_next[s]] = 1'b1;
					free_timer(s);
					fire.in_use = INUSE_W'(occupancy());
					have_fire = 1'b1;
				end
			end
		end
		if (have_fire) begin
			fire.last = 1'b1;
			due_results.push_back(fire);
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		timer_result_t want;
		if (due_results.size() == 0) begin
			$error("kind: expected no result, got %0d", m_tuser);
			mismatches++;
		end else begin
			want = due_results.pop_front();
			compare_field("kind", 32'(want.kind), 32'(m_tuser));
			compare_field("fired_action", 32'(want.action), 32'(m_tdata[ACTION_BITS-1:0]));
			compare_field("timers_in_use", 32'(want.in_use),
				32'(m_tdata[ACTION_BITS +: INUSE_W]));
			compare_field("last", 32'(want.last), 32'(m_tlast));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_busy[i]    = 1'b0;
				slot_running[i] = 1'b0;
				slot_linked[i]  = 1'b0;
			end
			tail_slot = -1;
			due_results.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_ADD)
					enter_timer(s_tdata[0], s_tdata[1], s_tdata[2 +: COUNT_BITS],
						s_tdata[2 + COUNT_BITS +: ACTION_BITS]);
				else
					tick_timers();
			end
			if (m_tvalid && m_tready)
				check_result();
		end
		results_due = due_results.size();
	end

endmodule

// ----- tb/chained_oneshot_timer_table_test.sv -----
// ----------------------------------------------------------------------------
// chained_oneshot_timer_table_test: stimulus and verdict for the timer table
// Resets the table once, then sends a directed run of adds and ticks (quiet
// tick, zero delay, chains that fire in one tick, tail removal, slot reuse, a
// timer that never expires, a full table) and a random mix of armed chains,
// odd adds and ticks. Both sides stall at random outside a quiet stretch;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module chained_oneshot_timer_table_test;
	import cot_pkg::*;

	localparam int SLOTS       = 8;
	localparam int COUNT_BITS  = 16;
	localparam int ACTION_BITS = 4;
	localparam int S_TDATA_W   = ((2 + COUNT_BITS + ACTION_BITS + 7) / 8) * 8;
	localparam int M_TDATA_W   = ((ACTION_BITS + INUSE_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 136;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = OP_TICK;
	logic                  m_tready = 1'b0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;
	int                    mismatches;
	int                    results_due;
	bit                    quiet_run = 1'b0;

	chained_oneshot_timer_table #(
		.SLOTS(SLOTS),
		.COUNT_BITS(COUNT_BITS),
		.ACTION_BITS(ACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	chained_oneshot_timer_table_checker #(
		.SLOTS(SLOTS),
		.COUNT_BITS(COUNT_BITS),
		.ACTION_BITS(ACTION_BITS),
		.S_TDATA_W(S_TDATA_W),
		.M_TDATA_W(M_TDATA_W)
	) table_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.mismatches(mismatches),
		.results_due(results_due)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("chained_oneshot_timer_table test failed");
		$finish;
	end

	always @(posedge clk) begin
		m_tready <= quiet_run || ($urandom_range(99) >= 19);
	end

	task automatic send_item(input logic op, input logic armed_now, input logic link,
			input logic [COUNT_BITS-1:0] delay, input logic [ACTION_BITS-1:0] act);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[0] = armed_now;
		word[1] = link;
		word[2 +: COUNT_BITS] = delay;
		word[2 + COUNT_BITS +: ACTION_BITS] = act;
		if (!quiet_run) begin
			while ($urandom_range(99) < 19) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_tick();
		send_item(OP_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
			COUNT_BITS'($urandom_range(65535)), ACTION_BITS'($urandom_range(15)));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (results_due != 0);
		@(posedge clk);
	endtask

	initial begin
		int n_random;
		int pick;
		int chain;
		logic [1:0] flags;
		logic [COUNT_BITS-1:0] delay;
		bit paused;

		n_random = 0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_tick();
		send_item(OP_ADD, 1'b1, 1'b1, '0, ACTION_BITS'(15));
		send_tick();
		send_item(OP_ADD, 1'b1, 1'b0, COUNT_BITS'(2), ACTION_BITS'(1));
		send_item(OP_ADD, 1'b0, 1'b1, COUNT_BITS'(1), ACTION_BITS'(2));
		send_item(OP_ADD, 1'b0, 1'b1, '0, ACTION_BITS'(3));
		send_tick();
		send_tick();
		send_item(OP_ADD, 1'b1, 1'b0, COUNT_BITS'(6), ACTION_BITS'(4));
		send_item(OP_ADD, 1'b1, 1'b1, COUNT_BITS'(1), ACTION_BITS'(5));
		send_tick();
		send_item(OP_ADD, 1'b0, 1'b1, COUNT_BITS'(2), ACTION_BITS'(6));
		send_item(OP_ADD, 1'b1, 1'b0, COUNT_BITS'(1), ACTION_BITS'(7));
		send_tick();
		send_item(OP_ADD, 1'b0, 1'b0, '1, '0);
		for (int i = 0; i < 9; i++)
			send_item(OP_ADD, 1'b1, 1'(i), COUNT_BITS'(12 + i), ACTION_BITS'(i + 6));
		drain_results();

		while (n_random < RANDOM_ITEMS) begin
			quiet_run = (n_random >= 60 && n_random < 100);
			if (n_random >= 80 && !paused) begin
				drain_results();
				paused = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 30) begin
				chain = $urandom_range(3);
				send_item(OP_ADD, 1'b1, 1'($urandom_range(1)), COUNT_BITS'($urandom_range(6)),
					ACTION_BITS'($urandom_range(15)));
				for (int c = 0; c < chain; c++)
					send_item(OP_ADD, 1'b0, 1'b1, COUNT_BITS'($urandom_range(6)),
						ACTION_BITS'($urandom_range(15)));
				n_random += chain + 1;
			end else if (pick < 40) begin
				flags = 2'($urandom_range(1, 3));
				if ($urandom_range(19) == 0)
					delay = COUNT_BITS'($urandom_range(65535));
				else
					delay = COUNT_BITS'($urandom_range(40));
				send_item(OP_ADD, flags[0], flags[1], delay, ACTION_BITS'($urandom_range(15)));
				n_random++;
			end else begin
				send_tick();
				n_random++;
			end
		end
		quiet_run = 1'b0;

		drain_results();
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("chained_oneshot_timer_table test passed");
		else
			$display("chained_oneshot_timer_table test failed");
		$finish;
	end

endmodule
